[sv/min_heap_timer_queue_core_assert.svh]
// Assertion macros used by the min-heap timer queue RTL.
`ifndef MIN_HEAP_TIMER_QUEUE_CORE_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min heap timer queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MHTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min heap timer queue: next-cycle check failed");

`endif

[sv/mhtq_pkg.sv]
// Package with sizes, codes, transaction types and helpers of the timer queue.
`default_nettype none

package mhtq_pkg;

  localparam int HEAP_DEPTH = 32;
  localparam int ID_COUNT   = 256;
  localparam int TIME_WIDTH = 32;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 8;
  localparam int TV_W   = 32;
  localparam int KIND_W = 3;

  localparam int IDX_W  = $clog2(HEAP_DEPTH);
  localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
  localparam int WIDE_W = IDX_W + 2;

  localparam int ID_SPAN    = 2 ** ID_W;
  localparam int MARK_COUNT = (ID_COUNT < ID_SPAN) ? ID_COUNT : ID_SPAN;
  localparam int MARK_W     = (MARK_COUNT > 1) ? $clog2(MARK_COUNT) : 1;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POPPED    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_POP_EMPTY = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  timer_id;
    logic [TV_W-1:0]  time_value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   out_id;
    logic [TV_W-1:0]   out_expiry;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] expiry;
    logic [ID_W-1:0]       id;
  } entry_t;

  typedef logic [MARK_W-1:0] mark_tab_t [ID_SPAN];

  function automatic mark_tab_t build_mark_tab();
    mark_tab_t tab;
    for (int i = 0; i < ID_SPAN; i++) begin
      tab[i] = MARK_W'(i % MARK_COUNT);
    end
    return tab;
  endfunction

  localparam mark_tab_t MARK_TAB = build_mark_tab();

  function automatic logic [TIME_WIDTH-1:0] field_to_time(logic [TV_W-1:0] v);
    logic [TIME_WIDTH+TV_W-1:0] w;
    w = {{TIME_WIDTH{1'b0}}, v};
    return w[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [TV_W-1:0] time_to_field(logic [TIME_WIDTH-1:0] t);
    logic [TIME_WIDTH+TV_W-1:0] w;
    w = {{TV_W{1'b0}}, t};
    return w[TV_W-1:0];
  endfunction

  function automatic out_item_t make_item(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                          logic [TV_W-1:0] expiry, logic last);
    out_item_t item;
    item.kind       = kind;
    item.out_id     = id;
    item.out_expiry = expiry;
    item.last       = last;
    return item;
  endfunction

endpackage

`default_nettype wire

[sv/min_heap_timer_queue_core.sv]
// Timer queue kept as a binary min-heap in a synchronous memory, ordered by expiry time.
// The cancel marks sit in a second, one-bit synchronous memory. After reset the controller
// clears all MARK_COUNT (256) cancel marks, and in_ready stays low meanwhile. One transaction
// is processed at a time and in_ready is high only while the controller is idle. Every heap
// level takes a read state and a compare state, because each step waits for the registered
// read of the heap memory. An add moves the new entry up a level at a time until it reaches
// the root or stops below it. A pop, and a tick for each due entry, moves the last entry to
// the root and sifts it down. A result that waits for out_ready holds the controller.
// Results leave through a one-entry output register, so the next transaction may be
// accepted while the final result still waits for out_ready.
`default_nettype none

module min_heap_timer_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhtq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mhtq_pkg::out_item_t out_data
);

  `include "min_heap_timer_queue_core_assert.svh"

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] S_DISP   = 4'd1;
  localparam logic [STATE_W-1:0] S_UP_RD  = 4'd2;
  localparam logic [STATE_W-1:0] S_UP_CMP = 4'd3;
  localparam logic [STATE_W-1:0] S_RT_RD  = 4'd4;
  localparam logic [STATE_W-1:0] S_RT_CMP = 4'd5;
  localparam logic [STATE_W-1:0] S_DN_RD  = 4'd6;
  localparam logic [STATE_W-1:0] S_DN_CMP = 4'd7;
  localparam logic [STATE_W-1:0] S_EMIT   = 4'd8;
  localparam logic [STATE_W-1:0] S_MK_CHK = 4'd9;
  localparam logic [STATE_W-1:0] S_CLR    = 4'd10;

  logic [STATE_W-1:0]                 state_r, state_nxt;
  logic [STATE_W-1:0]                 ret_r, ret_nxt;
  logic [mhtq_pkg::CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [mhtq_pkg::ID_W-1:0]          id_r, id_nxt;
  logic [mhtq_pkg::TIME_WIDTH-1:0]    tv_r, tv_nxt;
  logic [mhtq_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [mhtq_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  mhtq_pkg::entry_t                   sift_r, sift_nxt;
  mhtq_pkg::out_item_t                emit_r, emit_nxt;
  logic [mhtq_pkg::MARK_W-1:0]        clr_idx_r, clr_idx_nxt;

  mhtq_pkg::entry_t                   mem [mhtq_pkg::HEAP_DEPTH];
  mhtq_pkg::entry_t                   rd_a_r, rd_b_r;
  logic [mhtq_pkg::IDX_W-1:0]         rd_addr_a, rd_addr_b;
  logic                               wr_en;
  logic [mhtq_pkg::IDX_W-1:0]         wr_addr;
  mhtq_pkg::entry_t                   wr_data;

  logic                               marks_mem [mhtq_pkg::MARK_COUNT];
  logic                               mark_rd_r;
  logic                               mark_we, mark_wdata;
  logic [mhtq_pkg::MARK_W-1:0]        mark_waddr;
  logic [mhtq_pkg::MARK_W-1:0]        mark_idx;
  logic [mhtq_pkg::MARK_W-1:0]        root_mark_idx;
  logic [mhtq_pkg::IDX_W-1:0]         parent_idx;
  logic [mhtq_pkg::CNT_W-1:0]         cnt_m1;
  logic [mhtq_pkg::WIDE_W-1:0]        left_w, right_w, cnt_w;
  logic                               right_ok, take_right;
  mhtq_pkg::entry_t                   child;
  logic [mhtq_pkg::IDX_W-1:0]         child_idx;
  logic                               push_valid, push_ready;
  logic [STATE_W-1:0]                 done_state;

  assign in_ready      = (state_r == S_IDLE);
  assign push_valid    = (state_r == S_EMIT);
  assign mark_idx      = mhtq_pkg::MARK_TAB[id_r];
  assign root_mark_idx = mhtq_pkg::MARK_TAB[rd_a_r.id];
  assign parent_idx    = (idx_r - mhtq_pkg::IDX_W'(1)) >> 1;
  assign cnt_m1        = count_r - mhtq_pkg::CNT_W'(1);
  assign left_w        = mhtq_pkg::WIDE_W'({idx_r, 1'b1});
  assign right_w       = left_w + mhtq_pkg::WIDE_W'(1);
  assign cnt_w         = mhtq_pkg::WIDE_W'(count_r);
  assign right_ok      = (right_w < cnt_w);
  assign take_right    = right_ok && (rd_a_r.expiry > rd_b_r.expiry);
  assign child         = take_right ? rd_b_r : rd_a_r;
  assign child_idx     = take_right ? right_w[mhtq_pkg::IDX_W-1:0]
                                    : left_w[mhtq_pkg::IDX_W-1:0];
  assign done_state    = (cmd_r == mhtq_pkg::CMD_TICK) ? S_DISP : S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    tv_nxt      = tv_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    sift_nxt    = sift_r;
    emit_nxt    = emit_r;
    clr_idx_nxt = clr_idx_r;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = sift_r;
    mark_we     = 1'b0;
    mark_wdata  = 1'b0;
    mark_waddr  = mark_idx;
    unique case (state_r)
      S_CLR: begin
        mark_we     = 1'b1;
        mark_waddr  = clr_idx_r;
        clr_idx_nxt = clr_idx_r + mhtq_pkg::MARK_W'(1);
        if (clr_idx_r == mhtq_pkg::MARK_W'(mhtq_pkg::MARK_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          id_nxt    = in_data.timer_id;
          tv_nxt    = mhtq_pkg::field_to_time(in_data.time_value);
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cmd_r)
          mhtq_pkg::CMD_ADD: begin
            if (count_r == mhtq_pkg::CNT_W'(mhtq_pkg::HEAP_DEPTH)) begin
              emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_REJECTED, id_r, '0, 1'b1);
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end else begin
              idx_nxt   = count_r[mhtq_pkg::IDX_W-1:0];
              count_nxt = count_r + mhtq_pkg::CNT_W'(1);
              state_nxt = S_UP_RD;
            end
          end
          mhtq_pkg::CMD_CANCEL: begin
            mark_we    = 1'b1;
            mark_wdata = 1'b1;
            emit_nxt   = mhtq_pkg::make_item(mhtq_pkg::KIND_CANCELED, id_r, '0, 1'b1);
            ret_nxt    = S_IDLE;
            state_nxt  = S_EMIT;
          end
          mhtq_pkg::CMD_TICK: begin
            if (count_r == '0) begin
              emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_TICK_DONE, '0, '0, 1'b1);
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_RT_RD;
            end
          end
          mhtq_pkg::CMD_POP: begin
            if (count_r == '0) begin
              emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_POP_EMPTY, '0, '0, 1'b1);
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_RT_RD;
            end
          end
        endcase
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          wr_data   = '{expiry: tv_r, id: id_r};
          mark_we   = 1'b1;
          emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_ADDED, id_r, '0, 1'b1);
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          rd_addr_a = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a_r.expiry > tv_r) begin
          wr_data   = rd_a_r;
          idx_nxt   = parent_idx;
          state_nxt = S_UP_RD;
        end else begin
          wr_data   = '{expiry: tv_r, id: id_r};
          mark_we   = 1'b1;
          emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_ADDED, id_r, '0, 1'b1);
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end
      end
      S_RT_RD: begin
        rd_addr_a = '0;
        rd_addr_b = cnt_m1[mhtq_pkg::IDX_W-1:0];
        state_nxt = S_RT_CMP;
      end
      S_RT_CMP: begin
        if (cmd_r == mhtq_pkg::CMD_POP || rd_a_r.expiry <= tv_r) begin
          count_nxt = cnt_m1;
          sift_nxt  = rd_b_r;
          idx_nxt   = '0;
          ret_nxt   = S_DN_RD;
          if (cmd_r == mhtq_pkg::CMD_POP) begin
            emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_POPPED, rd_a_r.id,
                                            mhtq_pkg::time_to_field(rd_a_r.expiry), 1'b1);
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_MK_CHK;
          end
        end else begin
          emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_TICK_DONE, '0, '0, 1'b1);
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end
      end
      S_MK_CHK: begin
        if (!mark_rd_r) begin
          emit_nxt  = mhtq_pkg::make_item(mhtq_pkg::KIND_EXPIRED, rd_a_r.id,
                                          mhtq_pkg::time_to_field(rd_a_r.expiry), 1'b0);
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (left_w < cnt_w) begin
          rd_addr_a = left_w[mhtq_pkg::IDX_W-1:0];
          rd_addr_b = right_w[mhtq_pkg::IDX_W-1:0];
          state_nxt = S_DN_CMP;
        end else begin
          wr_en     = (count_r != '0);
          state_nxt = done_state;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (sift_r.expiry > child.expiry) begin
          wr_data   = child;
          idx_nxt   = child_idx;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = done_state;
        end
      end
      S_EMIT: begin
        if (push_ready) begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      count_r   <= '0;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r  <= ret_nxt;
    cmd_r  <= cmd_nxt;
    id_r   <= id_nxt;
    tv_r   <= tv_nxt;
    idx_r  <= idx_nxt;
    sift_r <= sift_nxt;
    emit_r <= emit_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_r <= marks_mem[root_mark_idx];
  end

  mhtq_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (emit_r),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `MHTQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
                    count_r <= mhtq_pkg::CNT_W'(mhtq_pkg::HEAP_DEPTH))
  `MHTQ_ASSERT_SAME(a_write_in_heap, clk, rst_n, wr_en,
                    mhtq_pkg::WIDE_W'(wr_addr) < cnt_w)
  `MHTQ_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && in_ready,
                    state_r == S_DISP)
  `MHTQ_ASSERT_NEXT(a_emit_hold, clk, rst_n, (state_r == S_EMIT) && !push_ready,
                    (state_r == S_EMIT) && $stable(emit_r))
  `MHTQ_ASSERT_NEXT(a_idle_count_stable, clk, rst_n, state_r == S_IDLE,
                    $stable(count_r))

endmodule

`default_nettype wire

[sv/mhtq_out_buf.sv]
// Single-entry output register between the queue controller and the result channel.
`default_nettype none

module mhtq_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  mhtq_pkg::out_item_t push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mhtq_pkg::out_item_t out_data
);

  logic               valid_r;
  mhtq_pkg::out_item_t data_r;

  assign push_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

[verif/min_heap_timer_queue_checker.sv]
// Checker that predicts the timer queue results and compares every output transaction.
module min_heap_timer_queue_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mhtq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mhtq_pkg::out_item_t out_data,
  output int                  fault_count,
  output int                  awaited_count,
  output int                  results_checked,
  output int                  longest_burst
);
  timeunit 1ns;
  timeprecision 1ps;

  import mhtq_pkg::*;

  entry_t    heap_slots [HEAP_DEPTH];
  int        held;
  bit        cancel_flags [ID_COUNT];
  out_item_t awaited_results [$];

  task automatic note_mismatch(input string what);
    $display("%0t ns: mismatch on result %0d: %s", $realtime, results_checked, what);
    fault_count++;
  endtask

  function automatic out_item_t shape(input logic [KIND_W-1:0] kind,
                                      input logic [ID_W-1:0] id,
                                      input logic [TIME_WIDTH-1:0] expiry);
    out_item_t r;
    r.kind       = kind;
    r.out_id     = id;
    r.out_expiry = TV_W'(expiry);
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic void heap_insert(input logic [ID_W-1:0] id,
                                      input logic [TIME_WIDTH-1:0] expiry);
    int slot;
    int parent;
    slot = held;
    held++;
    while (slot > 0) begin
      parent = (slot - 1) / 2;
      if (heap_slots[parent].expiry > expiry) begin
        heap_slots[slot] = heap_slots[parent];
        slot = parent;
      end else begin
        break;
      end
    end
    heap_slots[slot].expiry = expiry;
    heap_slots[slot].id     = id;
  endfunction

  function automatic void heap_drop_root();
    entry_t moving;
    int     slot;
    int     child;
    held--;
    heap_slots[0] = heap_slots[held];
    moving = heap_slots[0];
    slot = 0;
    while (slot * 2 + 1 < held) begin
      child = slot * 2 + 1;
      if (child + 1 < held && heap_slots[child].expiry > heap_slots[child + 1].expiry) begin
        child++;
      end
      if (moving.expiry > heap_slots[child].expiry) begin
        heap_slots[slot] = heap_slots[child];
        slot = child;
      end else begin
        break;
      end
    end
    heap_slots[slot] = moving;
  endfunction

  function automatic void apply_command(input in_item_t cmd_in);
    out_item_t             batch [HEAP_DEPTH + 1];
    int                    n;
    logic [TIME_WIDTH-1:0] tv;
    entry_t                root;
    n = 0;
    tv = cmd_in.time_value[TIME_WIDTH-1:0];
    case (cmd_in.cmd)
      CMD_ADD: begin
        if (held >= HEAP_DEPTH) begin
          batch[n] = shape(KIND_REJECTED, cmd_in.timer_id, '0);
          n++;
        end else begin
          heap_insert(cmd_in.timer_id, tv);
          cancel_flags[int'(cmd_in.timer_id) % ID_COUNT] = 1'b0;
          batch[n] = shape(KIND_ADDED, cmd_in.timer_id, '0);
          n++;
        end
      end
      CMD_CANCEL: begin
        cancel_flags[int'(cmd_in.timer_id) % ID_COUNT] = 1'b1;
        batch[n] = shape(KIND_CANCELED, cmd_in.timer_id, '0);
        n++;
      end
      CMD_TICK: begin
        while (held > 0 && heap_slots[0].expiry <= tv) begin
          root = heap_slots[0];
          heap_drop_root();
          if (!cancel_flags[int'(root.id) % ID_COUNT] && n < HEAP_DEPTH) begin
            batch[n] = shape(KIND_EXPIRED, root.id, root.expiry);
            n++;
          end
        end
        batch[n] = shape(KIND_TICK_DONE, '0, '0);
        n++;
      end
      default: begin
        if (held == 0) begin
          batch[n] = shape(KIND_POP_EMPTY, '0, '0);
          n++;
        end else begin
          root = heap_slots[0];
          heap_drop_root();
          batch[n] = shape(KIND_POPPED, root.id, root.expiry);
          n++;
        end
      end
    endcase
    batch[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      awaited_results.push_back(batch[i]);
    end
    if (n > longest_burst) begin
      longest_burst = n;
    end
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      note_mismatch($sformatf("unexpected result kind %0d id %0d", got.kind, got.out_id));
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind !== want.kind) begin
      note_mismatch($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
    end
    if (got.out_id !== want.out_id) begin
      note_mismatch($sformatf("id %0d, predicted %0d", got.out_id, want.out_id));
    end
    if (got.out_expiry !== want.out_expiry) begin
      note_mismatch($sformatf("expiry %0h, predicted %0h", got.out_expiry, want.out_expiry));
    end
    if (got.last !== want.last) begin
      note_mismatch($sformatf("last %0b, predicted %0b", got.last, want.last));
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      held = 0;
      foreach (cancel_flags[i]) begin
        cancel_flags[i] = 1'b0;
      end
      fault_count = 0;
      results_checked = 0;
      longest_burst = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
      if (in_valid && in_ready) begin
        apply_command(in_data);
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

[verif/min_heap_timer_queue_core_test.sv]
// Testbench top that drives the timer queue with directed and random commands.
module min_heap_timer_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mhtq_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int ITEM_TARGET = 210;
  localparam int CALM_TAIL   = 30;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fault_count;
  int awaited_count;
  int results_checked;
  int longest_burst;

  int              cmd_tally [4];
  int              items_sent;
  int              fills;
  logic            calm;
  logic [TV_W-1:0] wall_clock;

  always #(CLK_PERIOD / 2) clk = ~clk;

  min_heap_timer_queue_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  min_heap_timer_queue_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fault_count     (fault_count),
    .awaited_count   (awaited_count),
    .results_checked (results_checked),
    .longest_burst   (longest_burst)
  );

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                       input logic [TV_W-1:0] tv);
    in_item_t item;
    item.cmd        = cmd;
    item.timer_id   = id;
    item.time_value = tv;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    cmd_tally[cmd]++;
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
  endtask

  task automatic fill_heap();
    repeat (HEAP_DEPTH + 2) begin
      issue(CMD_ADD, ID_W'($urandom),
            ($urandom_range(0, 1) == 0) ? $urandom : wall_clock + $urandom_range(0, 500));
    end
    drain_results();
    issue(CMD_TICK, ID_W'($urandom), '1);
  endtask

  task automatic random_command();
    int              pick;
    logic [ID_W-1:0] id;
    logic [TV_W-1:0] tv;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 2) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
    tv = $urandom;
    if (pick < 45) begin
      case ($urandom_range(0, 7))
        0: tv = '0;
        1: tv = '1;
        2: ;
        default: tv = wall_clock + $urandom_range(0, 400);
      endcase
      issue(CMD_ADD, id, tv);
    end else if (pick < 62) begin
      issue(CMD_CANCEL, id, tv);
    end else if (pick < 85) begin
      wall_clock = wall_clock + $urandom_range(0, 150);
      if ($urandom_range(0, 9) != 0) begin
        tv = wall_clock;
      end
      issue(CMD_TICK, id, tv);
    end else begin
      issue(CMD_POP, id, tv);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    calm       = 1'b0;
    wall_clock = '0;
    items_sent = 0;
    fills      = 0;
    foreach (cmd_tally[i]) begin
      cmd_tally[i] = 0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    issue(CMD_POP, 8'h5A, 32'hDEAD_BEEF);
    issue(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    issue(CMD_ADD, 8'h00, 32'h0000_0000);
    issue(CMD_ADD, 8'hFF, 32'hFFFF_FFFF);
    issue(CMD_ADD, 8'd10, 32'd100);
    issue(CMD_ADD, 8'd11, 32'd100);
    issue(CMD_ADD, 8'd20, 32'd50);
    issue(CMD_ADD, 8'd12, 32'd100);
    issue(CMD_CANCEL, 8'd11, 32'hFFFF_FFFF);
    issue(CMD_CANCEL, 8'd200, 32'h0);
    issue(CMD_TICK, 8'd0, 32'd99);
    issue(CMD_TICK, 8'd0, 32'd100);
    issue(CMD_CANCEL, 8'hFF, 32'h0);
    issue(CMD_POP, 8'h00, 32'h0);
    issue(CMD_POP, 8'hFF, 32'hFFFF_FFFF);
    issue(CMD_ADD, 8'd11, 32'd7);
    issue(CMD_TICK, 8'd0, 32'd7);
    issue(CMD_CANCEL, 8'd50, 32'd0);
    issue(CMD_ADD, 8'd50, 32'd3);
    issue(CMD_ADD, 8'd51, 32'd3);
    issue(CMD_POP, 8'd0, 32'd0);
    issue(CMD_TICK, 8'd0, 32'd3);
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - CALM_TAIL) begin
        calm = 1'b1;
      end
      if (items_sent <= ITEM_TARGET - CALM_TAIL - HEAP_DEPTH - 4 &&
          ((fills == 0 && items_sent >= 70) || $urandom_range(0, 39) == 0)) begin
        fill_heap();
        fills++;
      end else begin
        random_command();
      end
    end

    drain_results();
    repeat (60) @(negedge clk);

    $display("Covered %0d commands: %0d adds, %0d cancels, %0d ticks, %0d pops, %0d fill-ups.",
             items_sent, cmd_tally[CMD_ADD], cmd_tally[CMD_CANCEL], cmd_tally[CMD_TICK],
             cmd_tally[CMD_POP], fills);
    $display("Checked %0d results; the largest burst from one command was %0d.",
             results_checked, longest_burst);
    if (fault_count == 0 && awaited_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[min_heap_timer_queue_core.f]
+incdir+sv
sv/mhtq_pkg.sv
sv/mhtq_out_buf.sv
sv/min_heap_timer_queue_core.sv
verif/min_heap_timer_queue_checker.sv
verif/min_heap_timer_queue_core_test.sv
